@@ rtl/core/sip_pkg.sv @@
// Shared types and constants for the saturating integer power block.
`timescale 1ns / 1ps

package sip_pkg;

   localparam int FIELD_W     = 32;
   localparam int W_EFF_W     = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH_SELECT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIGNED_MODE  = 2'd1;

   localparam logic [1:0] WSEL_8  = 2'd0;
   localparam logic [1:0] WSEL_16 = 2'd1;

   localparam logic [W_EFF_W-1:0] WIDTH_8  = 6'd8;
   localparam logic [W_EFF_W-1:0] WIDTH_16 = 6'd16;
   localparam logic [W_EFF_W-1:0] WIDTH_32 = 6'd32;

   typedef struct packed {
      logic load;
      logic init;
      logic mul;
      logic mul_sq;
      logic wr_r;
      logic wr_sq;
      logic shift;
   } sip_cmd_type;

   typedef struct packed {
      logic special;
      logic e_zero;
      logic e_odd;
      logic e_more;
   } sip_status_type;

endpackage

@@ rtl/core/sip_datapath.sv @@
// Operand decode, shared saturating multiplier and power registers.
`timescale 1ns / 1ps

module sip_datapath #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                          clock,
   input  logic [1:0]                    width_select,
   input  logic                          signed_mode,
   input  logic [sip_pkg::FIELD_W-1:0]   base_bits,
   input  logic [sip_pkg::FIELD_W-1:0]   exponent_bits,
   input  sip_pkg::sip_cmd_type          cmd,
   output sip_pkg::sip_status_type       status,
   output logic [sip_pkg::FIELD_W-1:0]   power_bits
);
   import sip_pkg::*;

   localparam int DW = MAX_WIDTH;
   localparam int PW = 2 * DW + 2;
   localparam logic signed [DW:0] ONE     = (DW + 1)'(1);
   localparam logic signed [DW:0] NEG_ONE = '1;

   logic [W_EFF_W-1:0]   w_eff;
   logic [DW-1:0]        mask;
   logic [DW-1:0]        top_bit;
   logic [DW-1:0]        a_raw;
   logic [DW-1:0]        b_raw;
   logic signed [DW:0]   a_ext;
   logic signed [DW:0]   b_ext;
   logic signed [DW:0]   hi;
   logic signed [DW:0]   lo;
   logic signed [PW-1:0] hi_w;
   logic signed [PW-1:0] lo_w;
   logic signed [DW:0]   op_a;
   logic signed [DW:0]   sat_val;
   logic signed [DW:0]   special_val;

   logic signed [DW:0]   a_ff, a_in;
   logic signed [DW:0]   b_ff, b_in;
   logic signed [DW:0]   r_ff, r_in;
   logic signed [DW:0]   sq_ff, sq_in;
   logic [DW-1:0]        e_ff, e_in;
   logic signed [PW-1:0] prod_ff, prod_in;

   always_comb begin
      case (width_select)
         WSEL_8:  w_eff = WIDTH_8;
         WSEL_16: w_eff = WIDTH_16;
         default: w_eff = WIDTH_32;
      endcase
      if (w_eff > W_EFF_W'(DW)) begin
         w_eff = W_EFF_W'(DW);
      end
   end

   always_comb begin
      for (int i = 0; i < DW; i++) begin
         mask[i] = (W_EFF_W'(i) < w_eff);
      end
   end

   assign top_bit = mask ^ (mask >> 1);
   assign a_raw   = base_bits[DW-1:0] & mask;
   assign b_raw   = exponent_bits[DW-1:0] & mask;

   assign a_ext = (signed_mode && |(a_raw & top_bit)) ? {1'b1, a_raw | ~mask} : {1'b0, a_raw};
   assign b_ext = (signed_mode && |(b_raw & top_bit)) ? {1'b1, b_raw | ~mask} : {1'b0, b_raw};

   assign hi   = signed_mode ? {1'b0, mask >> 1} : {1'b0, mask};
   assign lo   = signed_mode ? ~{1'b0, mask >> 1} : '0;
   assign hi_w = PW'(hi);
   assign lo_w = PW'(lo);

   assign op_a    = cmd.mul_sq ? sq_ff : r_ff;
   assign prod_in = op_a * sq_ff;

   always_comb begin
      if (prod_ff > hi_w) begin
         sat_val = hi;
      end else if (prod_ff < lo_w) begin
         sat_val = lo;
      end else begin
         sat_val = prod_ff[DW:0];
      end
   end

   always_comb begin
      if (b_ff == '0 || a_ff == ONE) begin
         special_val = ONE;
      end else if (a_ff == NEG_ONE) begin
         special_val = b_ff[0] ? NEG_ONE : ONE;
      end else begin
         special_val = '0;
      end
   end

   assign status.special = (b_ff == '0) || (a_ff == ONE) || b_ff[DW];
   assign status.e_zero  = (e_ff == '0);
   assign status.e_odd   = e_ff[0];
   assign status.e_more  = |e_ff[DW-1:1];

   always_comb begin
      a_in  = a_ff;
      b_in  = b_ff;
      r_in  = r_ff;
      sq_in = sq_ff;
      e_in  = e_ff;
      if (cmd.load) begin
         a_in = a_ext;
         b_in = b_ext;
      end
      if (cmd.init) begin
         r_in  = status.special ? special_val : a_ff;
         sq_in = a_ff;
         e_in  = b_ff[DW-1:0] - DW'(1);
      end
      if (cmd.wr_r) begin
         r_in = sat_val;
      end
      if (cmd.wr_sq) begin
         sq_in = sat_val;
      end
      if (cmd.shift) begin
         e_in = e_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      b_ff  <= b_in;
      r_ff  <= r_in;
      sq_ff <= sq_in;
      e_ff  <= e_in;
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

   assign power_bits = FIELD_W'(r_ff[DW-1:0] & mask);

endmodule

@@ rtl/core/sip_ctrl.sv @@
// Sequencer for the square-and-multiply loop and the word handshakes.
`timescale 1ns / 1ps

module sip_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  sip_pkg::sip_status_type   status,
   output sip_pkg::sip_cmd_type      cmd
);
   import sip_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_STEP,
      S_MUL_R,
      S_SAT_R,
      S_MUL_SQ,
      S_SAT_SQ,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept = req_valid && !req_stall_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            state_in = status.special ? S_OUT : S_STEP;
         end
         S_STEP: begin
            if (status.e_zero) begin
               state_in = S_OUT;
            end else if (status.e_odd) begin
               state_in = S_MUL_R;
            end else begin
               state_in = S_MUL_SQ;
            end
         end
         S_MUL_R: begin
            state_in = S_SAT_R;
         end
         S_SAT_R: begin
            state_in = status.e_more ? S_MUL_SQ : S_OUT;
         end
         S_MUL_SQ: begin
            state_in = S_SAT_SQ;
         end
         S_SAT_SQ: begin
            state_in = S_STEP;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == S_IDLE) && accept;
      cmd.init   = (state_ff == S_INIT);
      cmd.mul    = (state_ff == S_MUL_R) || (state_ff == S_MUL_SQ);
      cmd.mul_sq = (state_ff == S_MUL_SQ);
      cmd.wr_r   = (state_ff == S_SAT_R);
      cmd.wr_sq  = (state_ff == S_SAT_SQ);
      cmd.shift  = (state_ff == S_SAT_R) ||
                   ((state_ff == S_STEP) && !status.e_zero && !status.e_odd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
         rsp_valid_ff <= (state_in == S_OUT);
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/saturating_integer_power.sv @@
// Top level of the saturating integer power block.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_base_bits, req_exponent_bits
//   rsp_      out        rsp_valid / rsp_stall  rsp_power_bits
//   csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// One word in flight. For a zero or negative exponent or a unit base the result is set
// in the init state and goes straight out; otherwise, with e = exponent - 1, the loop
// scans e from its low bit, multiplying the result by the square for each set bit and
// squaring below the top bit, through the shared multiplier, product register and clamp.
// Reset clears the sequencer and sets width to 8 bits, signed.
// req_stall is high during reset and from acceptance until the result leaves.
`timescale 1ns / 1ps

module saturating_integer_power #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sip_pkg::FIELD_W-1:0]       req_base_bits,
   input  logic [sip_pkg::FIELD_W-1:0]       req_exponent_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sip_pkg::FIELD_W-1:0]       rsp_power_bits,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sip_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sip_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sip_pkg::*;

   logic [1:0]     width_select_ff, width_select_in;
   logic           signed_mode_ff, signed_mode_in;
   sip_cmd_type    cmd;
   sip_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      width_select_in = width_select_ff;
      signed_mode_in  = signed_mode_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_WIDTH_SELECT: width_select_in = csr_data[1:0];
            REG_SIGNED_MODE:  signed_mode_in  = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_select_ff <= WSEL_8;
         signed_mode_ff  <= 1'b1;
      end else begin
         width_select_ff <= width_select_in;
         signed_mode_ff  <= signed_mode_in;
      end
   end

   sip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sip_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .width_select  (width_select_ff),
      .signed_mode   (signed_mode_ff),
      .base_bits     (req_base_bits),
      .exponent_bits (req_exponent_bits),
      .cmd           (cmd),
      .status        (status),
      .power_bits    (rsp_power_bits)
   );

endmodule
